// ===== hw/rtl/scancode_line_discipline_macros.svh =====
// ---------------------------------------------------------------------------
// Scancode line discipline assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SCANCODE_LINE_DISCIPLINE_MACROS_SVH
`define SCANCODE_LINE_DISCIPLINE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define SCLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scld: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SCLD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scld: assertion failed");

`else

`define SCLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCLD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/scld_pkg.sv =====
// ---------------------------------------------------------------------------
// scld_pkg
// Types, codes and the scan-code keymap shared by the line discipline.
// ---------------------------------------------------------------------------
package scld_pkg;

    localparam int LEN_W      = 14;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;
    localparam int TABLE_ROWS = 58;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF_BYTE  = 2'd1;

    localparam logic       CANONICAL_RST = 1'b1;
    localparam logic [7:0] EOF_BYTE_RST  = 8'd4;

    // Scan codes with special handling
    localparam logic [7:0] SC_ESC       = 8'h01;
    localparam logic [7:0] SC_CTRL_MK   = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK  = 8'h9D;
    localparam logic [7:0] SC_LSHIFT_MK = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MK = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CAPS      = 8'h3A;

    // Characters
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UP_C   = 8'h43;
    localparam logic [7:0] CH_UP_D   = 8'h44;
    localparam logic [7:0] CH_LO_C   = 8'h63;
    localparam logic [7:0] CH_LO_D   = 8'h64;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;

    typedef struct packed {
        logic [7:0] scan_code;
        logic       reader_waiting;
        logic       buffer_not_empty;
    } t_in_item;

    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_byte;
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       erase_last;
        logic       wake_reader;
        logic       kill_signal;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_CHAR   = 3'd0,
        CMD_WAKE   = 3'd1,
        CMD_BS     = 3'd2,
        CMD_TAB    = 3'd3,
        CMD_CTRL_D = 3'd4,
        CMD_CTRL_C = 3'd5
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] byte_val;
        logic       wake;
        logic       rw;
        logic       len_zero;
    } t_cmd;

    // Returns {shifted, plain} for one keymap row
    function automatic logic [15:0] keymap_pair(input logic [5:0] row);
        logic [15:0] p;
        case (row)
            6'd1:  p = 16'h1B1B;
            6'd2:  p = 16'h2131;
            6'd3:  p = 16'h4032;
            6'd4:  p = 16'h2333;
            6'd5:  p = 16'h2434;
            6'd6:  p = 16'h2535;
            6'd7:  p = 16'h5E36;
            6'd8:  p = 16'h2637;
            6'd9:  p = 16'h2A38;
            6'd10: p = 16'h2839;
            6'd11: p = 16'h2930;
            6'd12: p = 16'h5F2D;
            6'd13: p = 16'h2B3D;
            6'd14: p = 16'h0808;
            6'd15: p = 16'h0909;
            6'd16: p = 16'h5171;
            6'd17: p = 16'h5777;
            6'd18: p = 16'h4565;
            6'd19: p = 16'h5272;
            6'd20: p = 16'h5474;
            6'd21: p = 16'h5979;
            6'd22: p = 16'h5575;
            6'd23: p = 16'h4969;
            6'd24: p = 16'h4F6F;
            6'd25: p = 16'h5070;
            6'd26: p = 16'h7B5B;
            6'd27: p = 16'h7D5D;
            6'd28: p = 16'h0A0A;
            6'd30: p = 16'h4161;
            6'd31: p = 16'h5373;
            6'd32: p = 16'h4464;
            6'd33: p = 16'h4666;
            6'd34: p = 16'h4767;
            6'd35: p = 16'h4868;
            6'd36: p = 16'h4A6A;
            6'd37: p = 16'h4B6B;
            6'd38: p = 16'h4C6C;
            6'd39: p = 16'h3A3B;
            6'd40: p = 16'h2227;
            6'd41: p = 16'h7E60;
            6'd43: p = 16'h7C5C;
            6'd44: p = 16'h5A7A;
            6'd45: p = 16'h5878;
            6'd46: p = 16'h4363;
            6'd47: p = 16'h5676;
            6'd48: p = 16'h4262;
            6'd49: p = 16'h4E6E;
            6'd50: p = 16'h4D6D;
            6'd51: p = 16'h3C2C;
            6'd52: p = 16'h3E2E;
            6'd53: p = 16'h3F2F;
            6'd57: p = 16'h2020;
            default: p = 16'h0000;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/scancode_line_discipline.sv =====
// ---------------------------------------------------------------------------
// scancode_line_discipline
// Scan-code set 1 to terminal line-editor actions, split into a classifier,
// a two-entry command queue and a result sequencer.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready | o_out (t_out_item)
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  The classifier takes one scan code per cycle while the command queue has
//  room; modifier, escape and release codes push no command.
//  The sequencer emits one result per cycle while the output is not stalled:
//  a command expands to one result (char, wake, backspace), three (ctrl-C,
//  ctrl-D) or four (tab), so the sequencer, not the classifier, sets the rate.
//  Reset clears modifiers, line length, queue and output valid, and restores
//  canonical mode and the EOF byte 4; no clearing pass follows.
//  A stalled output holds its result; the queue then fills and the input
//  request waits, while configuration writes are always taken.
// ---------------------------------------------------------------------------
module scancode_line_discipline #(
    parameter int LINE_MAX = 8192
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  scld_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output scld_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [scld_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);

    logic           r_canonical;
    logic [7:0]     r_eof_byte;

    logic           q_not_full;
    logic           push;
    scld_pkg::t_cmd push_cmd;
    logic           pop;
    logic           head_valid;
    scld_pkg::t_cmd head_cmd;

    // Config writes never stall
    assign o_cfg_ready = 1'b1;

    // Register file: unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canonical <= scld_pkg::CANONICAL_RST;
            r_eof_byte  <= scld_pkg::EOF_BYTE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                scld_pkg::CFG_CANONICAL: r_canonical <= i_cfg_data[0];
                scld_pkg::CFG_EOF_BYTE:  r_eof_byte  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: accept the request, update key state, classify
    scld_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_canonical  (r_canonical),
        .i_eof_byte   (r_eof_byte),
        .i_q_not_full (q_not_full),
        .o_push       (push),
        .o_push_cmd   (push_cmd)
    );

    // Queue: decouple classification from result sequencing
    scld_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_cmd   (push_cmd),
        .o_not_full   (q_not_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_cmd   (head_cmd)
    );

    // Back: expand each command into its results
    scld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== hw/rtl/scld_queue.sv =====
// ---------------------------------------------------------------------------
// scld_queue
// Two-entry command queue between the classifier and the result sequencer.
// ---------------------------------------------------------------------------
module scld_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scld_pkg::t_cmd  i_push_cmd,
    output logic            o_not_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output scld_pkg::t_cmd  o_head_cmd
);

    scld_pkg::t_cmd                   r_mem [scld_pkg::Q_DEPTH];
    logic [scld_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [scld_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [scld_pkg::Q_CNT_W-1:0]     r_count;
    logic [scld_pkg::Q_CNT_W-1:0]     n_count;

    assign o_not_full   = (r_count != scld_pkg::Q_CNT_W'(scld_pkg::Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== hw/rtl/scld_front.sv =====
// ---------------------------------------------------------------------------
// scld_front
// Accept scan codes, track modifiers and line length, classify into commands.
// ---------------------------------------------------------------------------
module scld_front #(
    parameter int LINE_MAX = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  scld_pkg::t_in_item  i_in,
    input  logic                i_canonical,
    input  logic [7:0]          i_eof_byte,
    input  logic                i_q_not_full,
    output logic                o_push,
    output scld_pkg::t_cmd      o_push_cmd
);

    localparam int SumW = scld_pkg::LEN_W + 1;
    localparam logic [SumW-1:0] LineMaxExt = SumW'(LINE_MAX);

    logic                       r_shift;
    logic                       r_caps;
    logic                       r_ctrl;
    logic [scld_pkg::LEN_W-1:0] r_line_len;
    logic                       n_shift;
    logic                       n_caps;
    logic                       n_ctrl;
    logic [scld_pkg::LEN_W-1:0] n_line_len;

    logic                       accept;
    logic [15:0]                pair;
    logic [7:0]                 plain;
    logic [7:0]                 ch;
    logic [SumW-1:0]            sum1;
    logic [SumW-1:0]            sum4;
    logic [scld_pkg::LEN_W-1:0] sat1;
    logic [scld_pkg::LEN_W-1:0] sat4;
    logic                       has_cmd;
    scld_pkg::t_cmd             cmd;

    assign o_in_ready = i_q_not_full;
    assign accept     = i_in_valid && i_q_not_full;

    assign pair  = scld_pkg::keymap_pair(i_in.scan_code[5:0]);
    assign plain = pair[7:0];
    assign ch    = (r_shift ^ r_caps) ? pair[15:8] : pair[7:0];

    assign sum1 = {1'b0, r_line_len} + SumW'(1);
    assign sum4 = {1'b0, r_line_len} + SumW'(4);
    assign sat1 = (sum1 > LineMaxExt) ? LineMaxExt[scld_pkg::LEN_W-1:0]
                                      : sum1[scld_pkg::LEN_W-1:0];
    assign sat4 = (sum4 > LineMaxExt) ? LineMaxExt[scld_pkg::LEN_W-1:0]
                                      : sum4[scld_pkg::LEN_W-1:0];

    always_comb begin
        n_shift       = r_shift;
        n_caps        = r_caps;
        n_ctrl        = r_ctrl;
        n_line_len    = r_line_len;
        has_cmd       = 1'b0;
        cmd.kind      = scld_pkg::CMD_CHAR;
        cmd.byte_val  = ch;
        cmd.wake      = 1'b0;
        cmd.rw        = i_in.reader_waiting;
        cmd.len_zero  = (r_line_len == '0);
        unique case (i_in.scan_code) inside
            scld_pkg::SC_CTRL_MK:  n_ctrl = 1'b1;
            scld_pkg::SC_CTRL_BRK: n_ctrl = 1'b0;
            scld_pkg::SC_LSHIFT_MK, scld_pkg::SC_RSHIFT_MK: n_shift = 1'b1;
            scld_pkg::SC_LSHIFT_BRK, scld_pkg::SC_RSHIFT_BRK: n_shift = 1'b0;
            scld_pkg::SC_CAPS: n_caps = ~r_caps;
            scld_pkg::SC_ESC: ;
            default: begin
                if (i_in.scan_code < 8'(scld_pkg::TABLE_ROWS)) begin
                    if (r_ctrl && (plain == scld_pkg::CH_LO_D)) begin
                        has_cmd      = 1'b1;
                        cmd.kind     = scld_pkg::CMD_CTRL_D;
                        cmd.byte_val = i_eof_byte;
                    end else if (r_ctrl && (plain == scld_pkg::CH_LO_C)) begin
                        has_cmd  = 1'b1;
                        cmd.kind = scld_pkg::CMD_CTRL_C;
                    end else if (ch == scld_pkg::CH_BS) begin
                        if (r_line_len != '0) begin
                            has_cmd    = 1'b1;
                            cmd.kind   = scld_pkg::CMD_BS;
                            n_line_len = r_line_len - 1'b1;
                        end
                    end else if (ch == scld_pkg::CH_TAB) begin
                        has_cmd    = 1'b1;
                        cmd.kind   = scld_pkg::CMD_TAB;
                        n_line_len = sat4;
                    end else if (ch >= scld_pkg::PRINT_LO && ch <= scld_pkg::PRINT_HI) begin
                        has_cmd    = 1'b1;
                        cmd.kind   = scld_pkg::CMD_CHAR;
                        cmd.wake   = !i_canonical && i_in.reader_waiting;
                        n_line_len = sat1;
                    end else if (ch == scld_pkg::CH_NL) begin
                        // Newline wakes a waiting reader in either mode
                        has_cmd    = 1'b1;
                        cmd.kind   = scld_pkg::CMD_CHAR;
                        cmd.wake   = i_in.reader_waiting;
                        n_line_len = '0;
                    end else if (!i_canonical && i_in.reader_waiting
                                 && i_in.buffer_not_empty) begin
                        has_cmd  = 1'b1;
                        cmd.kind = scld_pkg::CMD_WAKE;
                    end
                end
            end
        endcase
    end

    assign o_push     = accept && has_cmd;
    assign o_push_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= 1'b0;
            r_caps     <= 1'b0;
            r_ctrl     <= 1'b0;
            r_line_len <= '0;
        end else if (accept) begin
            r_shift    <= n_shift;
            r_caps     <= n_caps;
            r_ctrl     <= n_ctrl;
            r_line_len <= n_line_len;
        end
    end

endmodule

// ===== hw/rtl/scld_back.sv =====
// ---------------------------------------------------------------------------
// scld_back
// Expand queued commands into result items, one per cycle while the output
// is not stalled, into an output register.
// ---------------------------------------------------------------------------
`include "scancode_line_discipline_macros.svh"

module scld_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  scld_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output scld_pkg::t_out_item o_out
);

    logic [1:0]          r_step;
    logic                r_out_valid;
    scld_pkg::t_out_item r_out;
    scld_pkg::t_out_item n_out;
    logic                load;
    logic                step_last;

    assign load  = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_pop = load && step_last;

    always_comb begin
        case (i_cmd.kind) inside
            scld_pkg::CMD_TAB:                      step_last = (r_step == 2'd3);
            scld_pkg::CMD_CTRL_D, scld_pkg::CMD_CTRL_C: step_last = (r_step == 2'd2);
            default:                                step_last = 1'b1;
        endcase
    end

    always_comb begin
        n_out      = '0;
        n_out.last = step_last;
        unique case (i_cmd.kind) inside
            scld_pkg::CMD_CHAR: begin
                n_out.store_valid = 1'b1;
                n_out.store_byte  = i_cmd.byte_val;
                n_out.echo_valid  = 1'b1;
                n_out.echo_byte   = i_cmd.byte_val;
                n_out.wake_reader = i_cmd.wake;
            end
            scld_pkg::CMD_WAKE: begin
                n_out.wake_reader = 1'b1;
            end
            scld_pkg::CMD_BS: begin
                n_out.erase_last = 1'b1;
                n_out.echo_valid = 1'b1;
                n_out.echo_byte  = scld_pkg::CH_BS;
            end
            scld_pkg::CMD_TAB: begin
                n_out.store_valid = 1'b1;
                n_out.store_byte  = scld_pkg::CH_SPACE;
                n_out.echo_valid  = 1'b1;
                n_out.echo_byte   = scld_pkg::CH_SPACE;
            end
            scld_pkg::CMD_CTRL_D, scld_pkg::CMD_CTRL_C: begin
                n_out.echo_valid = 1'b1;
                case (r_step)
                    2'd0:    n_out.echo_byte = scld_pkg::CH_NL;
                    2'd1:    n_out.echo_byte = scld_pkg::CH_CARET;
                    default: n_out.echo_byte = (i_cmd.kind == scld_pkg::CMD_CTRL_D)
                                               ? scld_pkg::CH_UP_D : scld_pkg::CH_UP_C;
                endcase
                if (i_cmd.kind == scld_pkg::CMD_CTRL_C) begin
                    n_out.kill_signal = (r_step == 2'd2);
                end else if (i_cmd.rw) begin
                    // EOF marker first on an empty line, then the newline
                    if (r_step == 2'd0) begin
                        n_out.store_valid = 1'b1;
                        n_out.store_byte  = i_cmd.len_zero ? i_cmd.byte_val
                                                           : scld_pkg::CH_NL;
                    end else if (r_step == 2'd1 && i_cmd.len_zero) begin
                        n_out.store_valid = 1'b1;
                        n_out.store_byte  = scld_pkg::CH_NL;
                    end
                    n_out.wake_reader = (r_step == 2'd2);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step      <= step_last ? 2'd0 : r_step + 2'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `SCLD_ASSERT_IMP(a_step_has_cmd, i_clk, i_rst_n, r_step != 2'd0, i_cmd_valid)
    `SCLD_ASSERT_IMP(a_step3_is_tab, i_clk, i_rst_n, r_step == 2'd3, i_cmd.kind == scld_pkg::CMD_TAB)
    `SCLD_ASSERT_IMP(a_kill_is_last, i_clk, i_rst_n, r_out_valid && r_out.kill_signal, r_out.last)
    `SCLD_ASSERT_NXT(a_pop_rewinds, i_clk, i_rst_n, o_pop, r_step == 2'd0)

endmodule
